// ===== design/axi_slave_memory_bridge_assert.svh =====
// Assertion macros used by the bridge module.
`ifndef AXI_SLAVE_MEMORY_BRIDGE_ASSERT_SVH
`define AXI_SLAVE_MEMORY_BRIDGE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define ASB_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASB_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/asb_pkg.sv =====
`timescale 1ns / 1ps
package asb_pkg;
   localparam int ADDR_W = 48;
   localparam int DATA_W = 64;
   localparam int ID_W = 8;
   localparam int LEN_W = 8;
   localparam int BYTES_W = 12;
   localparam int STORE_WORDS_DEF = 256;
   localparam int TRACK_DEPTH_DEF = 8;
   localparam int BRESP_DEPTH_DEF = 8;
   localparam logic [ADDR_W-1:0] UNC_LIMIT_RESET = 48'h0000_8000_0000;

   localparam logic [2:0] CMD_RADDR = 3'd0;
   localparam logic [2:0] CMD_RWORD = 3'd1;
   localparam logic [2:0] CMD_RTAKEN = 3'd2;
   localparam logic [2:0] CMD_WADDR = 3'd3;
   localparam logic [2:0] CMD_WBEAT = 3'd4;
   localparam logic [2:0] CMD_WACK = 3'd5;
   localparam logic [2:0] CMD_BTAKEN = 3'd6;

   localparam logic [1:0] KIND_RREQ = 2'd0;
   localparam logic [1:0] KIND_RBEAT = 2'd1;
   localparam logic [1:0] KIND_WREQ = 2'd2;
   localparam logic [1:0] KIND_BRSP = 2'd3;

   localparam logic [0:0] REG_UNC_LIMIT = 1'd0;

   typedef struct packed {
      logic [1:0] kind;
      logic [ADDR_W-1:0] mem_address;
      logic [BYTES_W-1:0] mem_bytes;
      logic uncacheable;
      logic is_instruction;
      logic [DATA_W-1:0] out_data;
      logic [ID_W-1:0] out_id;
      logic out_last;
   } rsp_type;

   function automatic logic [DATA_W-1:0] lane_mask(input logic [1:0] size);
      unique case (size)
         2'd0: lane_mask = 64'h0000_0000_0000_00ff;
         2'd1: lane_mask = 64'h0000_0000_0000_ffff;
         2'd2: lane_mask = 64'h0000_0000_ffff_ffff;
         default: lane_mask = '1;
      endcase
   endfunction
endpackage

// ===== design/axi_slave_memory_bridge.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Content
// req     | in        | tdata: command, address, axi_id, burst_len, beat_size,
//         |           |        instr_fetch, data_word, last_flag, retry_pending
// rsp     | out       | tdata: kind, mem_address, mem_bytes, uncacheable,
//         |           |        is_instruction, out_data, out_id, out_last
// csr     | in        | APB, register 0 uncacheable_limit
// One beat per cycle unless held; its result is valid in the output register
// in the next cycle. An R taken beat reads the read store first: it sits in
// the stage-2 register, holding the input, before its R beat is output. A
// waiting result holds the input; a new beat is taken whenever stage 2 is empty
// and the output register is empty or drained in the same cycle. Synchronous
// reset clears control state; the read store needs no clearing pass.
module axi_slave_memory_bridge
   import asb_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF,
   parameter int TRACK_DEPTH = TRACK_DEPTH_DEF,
   parameter int BRESP_DEPTH = BRESP_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // command[2:0] address[50:3] axi_id[58:51] burst_len[66:59] beat_size[68:67]
   // instr_fetch[69] data_word[133:70] last_flag[134] retry_pending[135]
   input  logic [135:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // kind[1:0] mem_address[49:2] mem_bytes[61:50] uncacheable[62]
   // is_instruction[63] out_data[127:64] out_id[135:128] out_last[136]
   output logic [143:0] rsp_tdata,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   localparam int SW_W = $clog2(STORE_WORDS);
   localparam int TK_W = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
   localparam int BQ_W = (BRESP_DEPTH > 1) ? $clog2(BRESP_DEPTH) : 1;
   localparam int TKC_W = $clog2(TRACK_DEPTH + 1);
   localparam int BQC_W = $clog2(BRESP_DEPTH + 1);

   logic [2:0] cmd;
   logic [ADDR_W-1:0] in_addr;
   logic [ID_W-1:0] in_id;
   logic [LEN_W-1:0] in_len;
   logic [1:0] in_size;
   logic in_ins, in_last, in_retry;
   logic [DATA_W-1:0] in_data;
   assign cmd = req_tdata[2:0];
   assign in_addr = req_tdata[50:3];
   assign in_id = req_tdata[58:51];
   assign in_len = req_tdata[66:59];
   assign in_size = req_tdata[68:67];
   assign in_ins = req_tdata[69];
   assign in_data = req_tdata[133:70];
   assign in_last = req_tdata[134];
   assign in_retry = req_tdata[135];

   logic [ADDR_W-1:0] unc_ff;
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2:2] == REG_UNC_LIMIT) ? {16'd0, unc_ff} : 64'd0;

   // stage-2 register for R beats
   logic s2_ff, s2_in;
   logic [2:0] s2_off_ff;
   logic [2:0] s2_baddr_ff;
   logic [1:0] s2_size_ff;
   logic s2_zero_ff, s2_fin_ff;

   rsp_type out_ff, out_in;
   logic outv_ff, outv_in;
   logic go;
   // stall if output busy or an R beat in stage 2 still holds the output slot
   assign req_tready = !s2_ff && (!outv_ff || rsp_tready);
   assign go = req_tvalid && req_tready;
   assign rsp_tvalid = outv_ff;
   assign rsp_tdata = {7'd0, out_ff.out_last, out_ff.out_id, out_ff.out_data,
                       out_ff.is_instruction, out_ff.uncacheable, out_ff.mem_bytes,
                       out_ff.mem_address, out_ff.kind};

   logic rbusy_ff, rready_ff;
   logic [ADDR_W-1:0] rstart_ff;
   logic [ID_W-1:0] rtag_ff;
   logic [LEN_W-1:0] rlen_ff, rbidx_ff, rfill_ff;
   logic [1:0] rsize_ff;
   logic wopen_ff;
   logic [ADDR_W-1:0] wstart_ff;
   logic [1:0] wsize_ff;
   logic [LEN_W-1:0] wlen_ff;
   logic [8:0] wseen_ff;

   logic [ID_W-1:0] tk_id_ff [TRACK_DEPTH];
   logic [8:0] tk_cnt_ff [TRACK_DEPTH];
   logic [TK_W-1:0] tk_head_ff;
   logic [TKC_W-1:0] tk_used_ff;
   logic [ID_W-1:0] bq_ff [BRESP_DEPTH];
   logic [BQ_W-1:0] bq_head_ff;
   logic [BQC_W-1:0] bq_used_ff;

   // read store
   logic st_we;
   logic [SW_W-1:0] st_waddr, st_raddr;
   logic [DATA_W-1:0] st_rdata;
   logic [LEN_W+3-1:0] off;
   logic [ADDR_W-1:0] rbaddr;
   assign st_we = go && cmd == CMD_RWORD && rbusy_ff && !rready_ff
                  && ({3'd0, rfill_ff} < 11'(STORE_WORDS));
   assign st_waddr = SW_W'(rfill_ff);
   assign off = 11'(rbidx_ff) << rsize_ff;
   assign st_raddr = SW_W'(off[LEN_W+2:3]);
   assign rbaddr = rstart_ff + ADDR_W'(off);

   asb_ram #(.WIDTH(DATA_W), .DEPTH(STORE_WORDS)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(in_data),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   logic [ADDR_W-1:0] wa;
   logic [31:0] tk_sum, bq_sum;
   logic [TK_W-1:0] tk_tail;
   logic [BQ_W-1:0] bq_tail;
   logic [DATA_W-1:0] rval;
   assign wa = wstart_ff + (ADDR_W'(wseen_ff) << wsize_ff);
   assign tk_sum = 32'(tk_head_ff) + 32'(tk_used_ff);
   assign bq_sum = 32'(bq_head_ff) + 32'(bq_used_ff);
   assign tk_tail = TK_W'((tk_sum >= 32'(TRACK_DEPTH)) ? tk_sum - 32'(TRACK_DEPTH) : tk_sum);
   assign bq_tail = BQ_W'((bq_sum >= 32'(BRESP_DEPTH)) ? bq_sum - 32'(BRESP_DEPTH) : bq_sum);
   assign rval = s2_zero_ff ? '0 :
      (((st_rdata >> {s2_off_ff, 3'd0}) & lane_mask(s2_size_ff)) << {s2_baddr_ff, 3'd0});

   always_comb begin
      s2_in = 1'b0;
      outv_in = outv_ff && !rsp_tready;
      out_in = out_ff;
      if (s2_ff) begin
         outv_in = 1'b1;
         out_in = '0;
         out_in.kind = KIND_RBEAT;
         out_in.out_data = rval;
         out_in.out_id = rtag_ff;
         out_in.out_last = s2_fin_ff;
      end
      if (go) begin
         case (cmd)
            CMD_RADDR: if (!rbusy_ff && !in_retry) begin
               outv_in = 1'b1;
               out_in = '0;
               out_in.kind = KIND_RREQ;
               out_in.mem_address = in_addr;
               out_in.mem_bytes = (BYTES_W'(in_len) + 12'd1) << in_size;
               out_in.uncacheable = in_addr < unc_ff;
               out_in.is_instruction = in_ins;
            end
            CMD_RTAKEN: if (rbusy_ff && rready_ff) s2_in = 1'b1;
            CMD_WBEAT: if (wopen_ff && !in_retry) begin
               outv_in = 1'b1;
               out_in = '0;
               out_in.kind = KIND_WREQ;
               out_in.mem_address = wa;
               out_in.mem_bytes = BYTES_W'(12'd1 << wsize_ff);
               out_in.uncacheable = wa < unc_ff;
               out_in.out_data = (in_data >> {wa[2:0], 3'd0}) & lane_mask(wsize_ff);
            end
            CMD_BTAKEN: if (bq_used_ff != '0) begin
               outv_in = 1'b1;
               out_in = '0;
               out_in.kind = KIND_BRSP;
               out_in.out_id = bq_ff[bq_head_ff];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (go && cmd == CMD_RTAKEN) begin
         s2_off_ff <= off[2:0];
         s2_baddr_ff <= rbaddr[2:0];
         s2_size_ff <= rsize_ff;
         s2_zero_ff <= {3'b0, off[LEN_W+2:3]} >= 11'(STORE_WORDS);
         s2_fin_ff <= rbidx_ff == rlen_ff;
      end
      if (go && cmd == CMD_WADDR && !wopen_ff && !in_retry
          && 32'(tk_used_ff) < TRACK_DEPTH) begin
         tk_id_ff[tk_tail] <= in_id;
         tk_cnt_ff[tk_tail] <= 9'(in_len) + 9'd1;
      end
      if (go && cmd == CMD_WACK && tk_used_ff != '0 && tk_cnt_ff[tk_head_ff] > 9'd1)
         tk_cnt_ff[tk_head_ff] <= tk_cnt_ff[tk_head_ff] - 9'd1;
      if (go && cmd == CMD_WACK && tk_used_ff != '0 && tk_cnt_ff[tk_head_ff] <= 9'd1
          && 32'(bq_used_ff) < BRESP_DEPTH)
         bq_ff[bq_tail] <= tk_id_ff[tk_head_ff];
      if (reset) begin
         s2_ff <= 1'b0; outv_ff <= 1'b0; unc_ff <= UNC_LIMIT_RESET;
         rbusy_ff <= 1'b0; rready_ff <= 1'b0; rstart_ff <= '0; rtag_ff <= '0;
         rlen_ff <= '0; rbidx_ff <= '0; rfill_ff <= '0; rsize_ff <= '0;
         wopen_ff <= 1'b0; wstart_ff <= '0; wsize_ff <= '0; wlen_ff <= '0;
         wseen_ff <= '0; tk_head_ff <= '0; tk_used_ff <= '0;
         bq_head_ff <= '0; bq_used_ff <= '0;
      end else begin
         s2_ff <= s2_in;
         outv_ff <= outv_in;
         if (csr_wr && csr_paddr[2:2] == REG_UNC_LIMIT) unc_ff <= csr_pwdata[ADDR_W-1:0];
         if (go) begin
            case (cmd)
               CMD_RADDR: if (!rbusy_ff && !in_retry) begin
                  rbusy_ff <= 1'b1; rready_ff <= 1'b0; rstart_ff <= in_addr;
                  rtag_ff <= in_id; rlen_ff <= in_len; rsize_ff <= in_size;
                  rbidx_ff <= '0; rfill_ff <= '0;
               end
               CMD_RWORD: if (rbusy_ff && !rready_ff) begin
                  rfill_ff <= rfill_ff + 8'd1;
                  if (in_last) rready_ff <= 1'b1;
               end
               CMD_RTAKEN: if (rbusy_ff && rready_ff) begin
                  if (rbidx_ff == rlen_ff) begin
                     rbusy_ff <= 1'b0; rready_ff <= 1'b0;
                  end else rbidx_ff <= rbidx_ff + 8'd1;
               end
               CMD_WADDR: if (!wopen_ff && !in_retry && 32'(tk_used_ff) < TRACK_DEPTH) begin
                  wopen_ff <= 1'b1; wstart_ff <= in_addr; wsize_ff <= in_size;
                  wlen_ff <= in_len; wseen_ff <= '0;
                  tk_used_ff <= tk_used_ff + 1'b1;
               end
               CMD_WBEAT: if (wopen_ff && !in_retry) begin
                  if (wseen_ff + 9'd1 == 9'(wlen_ff) + 9'd1 || in_last) begin
                     wopen_ff <= 1'b0; wseen_ff <= '0;
                  end else wseen_ff <= wseen_ff + 9'd1;
               end
               CMD_WACK: if (tk_used_ff != '0 && tk_cnt_ff[tk_head_ff] <= 9'd1
                             && 32'(bq_used_ff) < BRESP_DEPTH) begin
                  bq_used_ff <= bq_used_ff + 1'b1;
                  tk_head_ff <= (tk_head_ff == TK_W'(TRACK_DEPTH - 1)) ? '0
                                : tk_head_ff + TK_W'(1);
                  tk_used_ff <= tk_used_ff - 1'b1;
               end
               default: ;
            endcase
            if (cmd == CMD_BTAKEN && bq_used_ff != '0) begin
               bq_head_ff <= (bq_head_ff == BQ_W'(BRESP_DEPTH - 1)) ? '0
                             : bq_head_ff + BQ_W'(1);
               bq_used_ff <= (cmd == CMD_WACK) ? bq_used_ff : bq_used_ff - 1'b1;
            end
         end
      end
   end

`include "axi_slave_memory_bridge_assert.svh"
   `ASB_ASSERT_NEXT(a_s2_out, clock, reset, s2_ff, rsp_tvalid && out_ff.kind == KIND_RBEAT, "R beat lost")
   `ASB_ASSERT_IMPL(a_tk_bound, clock, reset, 1'b1, 32'(tk_used_ff) <= TRACK_DEPTH, "tracker overflow")
   `ASB_ASSERT_IMPL(a_bq_bound, clock, reset, 1'b1, 32'(bq_used_ff) <= BRESP_DEPTH, "B queue overflow")
   `ASB_ASSERT_IMPL(a_ready, clock, reset, rready_ff, rbusy_ff, "data ready without busy read")
endmodule

// ===== design/asb_ram.sv =====
`timescale 1ns / 1ps
module asb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import asb_pkg::*;

   localparam logic [2:0] CMD_NONE = 3'd7;

   typedef struct {
      logic [2:0] cmd;
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0] id;
      logic [LEN_W-1:0] len;
      logic [1:0] size;
      logic ins;
      logic [DATA_W-1:0] data;
      logic last;
      logic retry;
   } bridge_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [135:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   int errors = 0;
   int items_sent = 0;
   bit no_idle = 1'b0;

   logic [ADDR_W-1:0] unc_limit = UNC_LIMIT_RESET;
   bit rd_busy, rd_ready;
   logic [ADDR_W-1:0] rd_start;
   logic [7:0] rd_tag, rd_len, rd_beat, rd_fill;
   logic [1:0] rd_size;
   logic [63:0] rd_store [256];
   bit rd_written [256];
   bit wr_open;
   logic [ADDR_W-1:0] wr_start;
   logic [1:0] wr_size;
   logic [7:0] wr_len;
   logic [8:0] wr_seen;
   logic [7:0] track_id [$];
   int track_cnt [$];
   logic [7:0] bresp_ids [$];
   rsp_type pending_rsp [$];

   axi_slave_memory_bridge dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   int sink_hold = 0;
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         sink_hold <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [63:0] beat_mask(input logic [1:0] size);
      if (size == 2'd3) return '1;
      return (64'd1 << (8 << size)) - 64'd1;
   endfunction

   function automatic logic [ADDR_W-1:0] random_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic bridge_req_type random_req();
      bridge_req_type r;
      r.cmd = 3'($urandom_range(0, 7));
      r.addr = random_addr();
      r.id = 8'($urandom());
      r.len = 8'($urandom());
      r.size = 2'($urandom());
      r.ins = 1'($urandom());
      r.data = {$urandom(), $urandom()};
      r.last = 1'($urandom());
      r.retry = 1'($urandom());
      return r;
   endfunction

   task automatic predict(input bridge_req_type r);
      rsp_type e;
      logic [15:0] off;
      logic [63:0] val;
      logic [ADDR_W-1:0] a;
      e = '0;
      case (r.cmd)
         CMD_RADDR: begin
            if (!rd_busy && !r.retry) begin
               rd_busy = 1; rd_ready = 0; rd_start = r.addr; rd_tag = r.id;
               rd_len = r.len; rd_size = r.size; rd_beat = 0; rd_fill = 0;
               e.kind = KIND_RREQ;
               e.mem_address = r.addr;
               e.mem_bytes = (12'(r.len) + 12'd1) << r.size;
               e.uncacheable = r.addr < unc_limit;
               e.is_instruction = r.ins;
               pending_rsp.insert(pending_rsp.size(), e);
            end
         end
         CMD_RWORD: begin
            if (rd_busy && !rd_ready) begin
               rd_store[rd_fill] = r.data;
               rd_written[rd_fill] = 1;
               rd_fill = rd_fill + 8'd1;
               if (r.last) rd_ready = 1;
            end
         end
         CMD_RTAKEN: begin
            if (rd_busy && rd_ready) begin
               off = 16'(rd_beat) << rd_size;
               val = (rd_store[off >> 3] >> (off[2:0] * 8)) & beat_mask(rd_size);
               a = rd_start + ADDR_W'(off);
               e.kind = KIND_RBEAT;
               e.out_data = val << (a[2:0] * 8);
               e.out_id = rd_tag;
               e.out_last = rd_beat == rd_len;
               pending_rsp.insert(pending_rsp.size(), e);
               if (e.out_last) begin
                  rd_busy = 0; rd_ready = 0;
               end else begin
                  rd_beat = rd_beat + 8'd1;
               end
            end
         end
         CMD_WADDR: begin
            if (!wr_open && !r.retry && track_id.size() < TRACK_DEPTH_DEF) begin
               wr_open = 1; wr_start = r.addr; wr_size = r.size; wr_len = r.len;
               wr_seen = 0;
               track_id.insert(track_id.size(), r.id);
               track_cnt.insert(track_cnt.size(), int'(r.len) + 1);
            end
         end
         CMD_WBEAT: begin
            if (wr_open && !r.retry) begin
               a = wr_start + (ADDR_W'(wr_seen) << wr_size);
               e.kind = KIND_WREQ;
               e.mem_address = a;
               e.mem_bytes = 12'd1 << wr_size;
               e.uncacheable = a < unc_limit;
               e.out_data = (r.data >> (a[2:0] * 8)) & beat_mask(wr_size);
               pending_rsp.insert(pending_rsp.size(), e);
               wr_seen = wr_seen + 9'd1;
               if (wr_seen == 9'(wr_len) + 9'd1 || r.last) begin
                  wr_open = 0; wr_seen = 0;
               end
            end
         end
         CMD_WACK: begin
            if (track_id.size() > 0) begin
               if (track_cnt[0] <= 1) begin
                  if (bresp_ids.size() < BRESP_DEPTH_DEF) begin
                     bresp_ids.insert(bresp_ids.size(), track_id[0]);
                     track_id.delete(0);
                     track_cnt.delete(0);
                  end
               end else begin
                  track_cnt[0] = track_cnt[0] - 1;
               end
            end
         end
         CMD_BTAKEN: begin
            if (bresp_ids.size() > 0) begin
               e.kind = KIND_BRSP;
               e.out_id = bresp_ids[0];
               bresp_ids.delete(0);
               pending_rsp.insert(pending_rsp.size(), e);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send(input bridge_req_type r);
      logic [15:0] off;
      int gap;
      if (r.cmd == CMD_RTAKEN && rd_busy && rd_ready) begin
         off = 16'(rd_beat) << rd_size;
         if (!rd_written[off >> 3]) r.cmd = CMD_NONE;
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.retry, r.last, r.data, r.ins, r.size, r.len, r.id, r.addr, r.cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict(r);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_cmd(input logic [2:0] cmd);
      bridge_req_type r;
      r = random_req();
      r.cmd = cmd;
      send(r);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_limit(input logic [ADDR_W-1:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(REG_UNC_LIMIT) << 3;
      csr_pwdata <= 64'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      unc_limit = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic read_burst(input logic [ADDR_W-1:0] addr, input logic [7:0] len,
                             input logic [1:0] size);
      bridge_req_type r;
      int words;
      r = random_req();
      r.cmd = CMD_RADDR; r.addr = addr; r.len = len; r.size = size; r.retry = 0;
      send(r);
      if (!rd_busy) return;
      words = ((int'(len) << size) >> 3) + 1;
      for (int i = 0; i < words; i++) begin
         r = random_req();
         r.cmd = CMD_RWORD;
         r.last = i == words - 1;
         send(r);
      end
      for (int i = 0; i <= len; i++) send_cmd(CMD_RTAKEN);
   endtask

   task automatic write_burst(input logic [ADDR_W-1:0] addr, input logic [7:0] len,
                              input logic [1:0] size, input bit acks, input bit take_b);
      bridge_req_type r;
      r = random_req();
      r.cmd = CMD_WADDR; r.addr = addr; r.len = len; r.size = size; r.retry = 0;
      send(r);
      if (!wr_open) return;
      for (int i = 0; i <= len; i++) begin
         r = random_req();
         r.cmd = CMD_WBEAT;
         r.retry = 0;
         r.last = i == len;
         send(r);
      end
      if (acks) for (int i = 0; i <= len; i++) send_cmd(CMD_WACK);
      if (take_b) send_cmd(CMD_BTAKEN);
   endtask

   task automatic drain_writes();
      while (track_id.size() > 0 || bresp_ids.size() > 0) begin
         if (bresp_ids.size() > 0) send_cmd(CMD_BTAKEN);
         else send_cmd(CMD_WACK);
      end
   endtask

   task automatic test_read_extremes(input bit full_burst);
      read_burst('0, 8'd0, 2'd0);
      read_burst('1, 8'd3, 2'd1);
      if (full_burst) read_burst(48'h7fff_ffff, 8'd255, 2'd3);
      read_burst(48'h8000_0003, 8'd5, 2'd2);
   endtask

   task automatic test_write_extremes();
      write_burst('1, 8'd2, 2'd3, 1, 1);
      write_burst(48'h0000_0000_0005, 8'd0, 2'd0, 1, 1);
      write_burst(48'h8000_0002, 8'd1, 2'd1, 1, 1);
   endtask

   task automatic test_ignored_events();
      bridge_req_type r;
      send_cmd(CMD_RTAKEN);
      send_cmd(CMD_RWORD);
      send_cmd(CMD_WBEAT);
      send_cmd(CMD_WACK);
      send_cmd(CMD_BTAKEN);
      send_cmd(CMD_NONE);
      r = random_req(); r.cmd = CMD_RADDR; r.retry = 1; send(r);
      r = random_req(); r.cmd = CMD_WADDR; r.retry = 1; send(r);
   endtask

   task automatic test_queue_limits();
      for (int i = 0; i < TRACK_DEPTH_DEF + 2; i++)
         write_burst(random_addr(), 8'd0, 2'($urandom()), 0, 0);
      for (int i = 0; i < TRACK_DEPTH_DEF + 2; i++) send_cmd(CMD_WACK);
      drain_writes();
   endtask

   task automatic test_random_mix();
      int choice;
      logic [7:0] len;
      while (items_sent < 1000) begin
         choice = $urandom_range(0, 99);
         len = ($urandom_range(0, 99) < 97) ? 8'($urandom_range(0, 7)) : 8'($urandom());
         if (choice < 35) begin
            read_burst(random_addr(), len, 2'($urandom()));
         end else if (choice < 70) begin
            write_burst(random_addr(), len, 2'($urandom()),
                        $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 70);
         end else if (choice < 75) begin
            drain_writes();
         end else begin
            repeat ($urandom_range(1, 5)) send(random_req());
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type got, e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tdata[1:0];
         got.mem_address = rsp_tdata[49:2];
         got.mem_bytes = rsp_tdata[61:50];
         got.uncacheable = rsp_tdata[62];
         got.is_instruction = rsp_tdata[63];
         got.out_data = rsp_tdata[127:64];
         got.out_id = rsp_tdata[135:128];
         got.out_last = rsp_tdata[136];
         if (pending_rsp.size() == 0) begin
            $error("unexpected result kind %0d", got.kind);
            errors++;
         end else begin
            e = pending_rsp[0];
            pending_rsp.delete(0);
            if (got.kind !== e.kind) begin
               $error("kind exp %h got %h", e.kind, got.kind); errors++;
            end
            if (got.mem_address !== e.mem_address) begin
               $error("mem_address exp %h got %h", e.mem_address, got.mem_address); errors++;
            end
            if (got.mem_bytes !== e.mem_bytes) begin
               $error("mem_bytes exp %h got %h", e.mem_bytes, got.mem_bytes); errors++;
            end
            if (got.uncacheable !== e.uncacheable) begin
               $error("uncacheable exp %h got %h", e.uncacheable, got.uncacheable); errors++;
            end
            if (got.is_instruction !== e.is_instruction) begin
               $error("is_instruction exp %h got %h", e.is_instruction, got.is_instruction);
               errors++;
            end
            if (got.out_data !== e.out_data) begin
               $error("out_data exp %h got %h", e.out_data, got.out_data); errors++;
            end
            if (got.out_id !== e.out_id) begin
               $error("out_id exp %h got %h", e.out_id, got.out_id); errors++;
            end
            if (got.out_last !== e.out_last) begin
               $error("out_last exp %h got %h", e.out_last, got.out_last); errors++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      no_idle = 1'b1;
      test_read_extremes(1'b1);
      no_idle = 1'b0;
      test_write_extremes();
      test_ignored_events();
      write_limit('0);
      test_read_extremes(1'b0);
      test_write_extremes();
      write_limit('1);
      test_queue_limits();
      test_write_extremes();
      write_limit(random_addr());
      test_random_mix();
      write_limit(UNC_LIMIT_RESET);
      no_idle = 1'b1;
      repeat (40) send(random_req());
      no_idle = 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+design
design/asb_pkg.sv
design/asb_ram.sv
design/axi_slave_memory_bridge.sv
dv/testbench.sv
